// ----- hdl/clvp_pkg.sv -----
// ---------------------------------------------------------------------------
// clvp_pkg
// Shared constants, types and the value fold for the context load value
// predictor.
// ---------------------------------------------------------------------------
package clvp_pkg;

  // field widths
  localparam int PC_W    = 64;
  localparam int VALUE_W = 64;
  localparam int ID_W    = 16;
  localparam int HASH_W  = 16;

  // prediction table geometry
  localparam int PRED_ENTRIES  = 65536;
  localparam int PRED_IDX_BITS = $clog2(PRED_ENTRIES);

  // parameter defaults
  localparam int HIST_IDX_BITS_DEF = 10;
  localparam int CTX_DEPTH_DEF     = 4;

  // result of the context evaluation, handed from the context logic to the top
  typedef struct packed {
    logic              hit;
    logic [HASH_W-1:0] old_hash;
    logic [HASH_W-1:0] new_hash;
  } clvp_ctx_t;

  // xor-fold of a value into one 16-bit id
  function automatic logic [ID_W-1:0] value_id(input logic [VALUE_W-1:0] v);
    value_id = v[15:0] ^ v[31:16] ^ v[47:32] ^ v[63:48];
  endfunction

endpackage

// ----- hdl/clvp_ram.sv -----
// ---------------------------------------------------------------------------
// clvp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module clvp_ram
  import clvp_pkg::*;
#(
  parameter int WIDTH     = VALUE_W,
  parameter int ADDR_BITS = PRED_IDX_BITS
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [2**ADDR_BITS];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/clvp_ctx.sv -----
// ---------------------------------------------------------------------------
// clvp_ctx
// Context logic: tag check on a history entry, old and new context hash,
// and the updated history entry to write back.
// ---------------------------------------------------------------------------
module clvp_ctx
  import clvp_pkg::*;
#(
  parameter int HIST_IDX_BITS = HIST_IDX_BITS_DEF,
  parameter int CTX_DEPTH     = CTX_DEPTH_DEF,
  localparam int TAG_W = PC_W - HIST_IDX_BITS,
  localparam int IDS_W = ID_W * CTX_DEPTH,
  localparam int PTR_W = $clog2(CTX_DEPTH),
  localparam int ENT_W = 1 + TAG_W + IDS_W + PTR_W
) (
  input  logic [ENT_W-1:0] entry,
  input  logic [TAG_W-1:0] tag,
  input  logic [ID_W-1:0]  new_id,
  output clvp_ctx_t        ctx,
  output logic [ENT_W-1:0] new_entry
);

  logic             ent_valid;
  logic [TAG_W-1:0] ent_tag;
  logic [IDS_W-1:0] ent_ids;
  logic [PTR_W-1:0] ent_ptr;
  logic [IDS_W-1:0] upd_ids;
  logic [PTR_W-1:0] upd_ptr;
  logic [PTR_W:0]   ptr_inc;
  logic             hit;

  // context hash: ids oldest first, shifted by two bits per step toward newest
  function automatic logic [HASH_W-1:0] ctx_hash(input logic [IDS_W-1:0] ids,
                                                 input logic [PTR_W-1:0] ptr);
    logic [HASH_W-1:0] h;
    logic [PTR_W:0]    pos;
    logic [ID_W-1:0]   id;
    logic [HASH_W-1:0] sh;
    h = '0;
    for (int i = 0; i < CTX_DEPTH; i++) begin
      pos = {1'b0, ptr} + (PTR_W+1)'(i);
      if (pos >= (PTR_W+1)'(CTX_DEPTH)) begin
        pos = pos - (PTR_W+1)'(CTX_DEPTH);
      end
      id = '0;
      for (int k = 0; k < CTX_DEPTH; k++) begin
        if (pos == (PTR_W+1)'(k)) begin
          id = ids[k*ID_W +: ID_W];
        end
      end
      sh = HASH_W'(id) << (2 * (CTX_DEPTH - 1 - i));
      h  = h ^ sh;
    end
    ctx_hash = h;
  endfunction

  // unpack the entry
  assign ent_valid = entry[ENT_W-1];
  assign ent_tag   = entry[ENT_W-2 -: TAG_W];
  assign ent_ids   = entry[PTR_W +: IDS_W];
  assign ent_ptr   = entry[PTR_W-1:0];

  assign hit = ent_valid && (ent_tag == tag);

  // pointer advance with wrap
  assign ptr_inc = {1'b0, ent_ptr} + (PTR_W+1)'(1);

  // updated ring and pointer
  always_comb begin
    if (hit) begin
      upd_ids = ent_ids;
      for (int k = 0; k < CTX_DEPTH; k++) begin
        if (ent_ptr == PTR_W'(k)) begin
          upd_ids[k*ID_W +: ID_W] = new_id;
        end
      end
      if (ptr_inc >= (PTR_W+1)'(CTX_DEPTH)) begin
        upd_ptr = '0;
      end else begin
        upd_ptr = ptr_inc[PTR_W-1:0];
      end
    end else begin
      upd_ids             = '0;
      upd_ids[ID_W-1:0]   = new_id;
      upd_ptr             = PTR_W'(1);
    end
  end

  assign new_entry    = {1'b1, tag, upd_ids, upd_ptr};
  assign ctx.hit      = hit;
  assign ctx.old_hash = ctx_hash(ent_ids, ent_ptr);
  assign ctx.new_hash = ctx_hash(upd_ids, upd_ptr);

endmodule

// ----- hdl/context_load_value_predictor.sv -----
// ---------------------------------------------------------------------------
// context_load_value_predictor
// Finite context method load value predictor: tagged history ring per load
// PC in one RAM, context-hashed prediction table in a second RAM.
// ---------------------------------------------------------------------------
// pipeline: history RAM read, evaluate with prediction RAM read, result register
// a new request waits while busy, which covers the history RAM
//   read-modify-write (read, then evaluate and write back)
// results cannot be stalled: out_valid marks a single cycle
// reset: busy stays high while both RAMs are swept to zero, one entry per cycle,
//   over the depth of the larger RAM
module context_load_value_predictor
  import clvp_pkg::*;
#(
  parameter int HIST_IDX_BITS = HIST_IDX_BITS_DEF,
  parameter int CTX_DEPTH     = CTX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [PC_W-1:0]    in_load_pc,
  input  logic [VALUE_W-1:0] in_actual_value,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_predicted_value,
  output logic               out_prediction_correct,
  output logic               out_history_hit
);

  localparam int TAG_W    = PC_W - HIST_IDX_BITS;
  localparam int IDS_W    = ID_W * CTX_DEPTH;
  localparam int PTR_W    = $clog2(CTX_DEPTH);
  localparam int ENT_W    = 1 + TAG_W + IDS_W + PTR_W;
  localparam int CLR_BITS = (HIST_IDX_BITS > PRED_IDX_BITS) ? HIST_IDX_BITS : PRED_IDX_BITS;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CLR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                clearing;
  logic                evaluating;
  logic                accept;

  logic [PC_W-1:0]     pc_r;
  logic [VALUE_W-1:0]  val_r;

  logic                p2_vld_r;
  logic                p2_hit_r;
  logic [HASH_W-1:0]   p2_hash_r;
  logic [VALUE_W-1:0]  p2_val_r;

  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_pred_r;
  logic                out_correct_r;
  logic                out_hit_r;

  logic                     hist_we;
  logic [HIST_IDX_BITS-1:0] hist_waddr;
  logic [ENT_W-1:0]         hist_wdata;
  logic [ENT_W-1:0]         hist_rdata;
  logic [ENT_W-1:0]         new_entry;
  clvp_ctx_t                ctx;

  logic                     pred_we;
  logic [PRED_IDX_BITS-1:0] pred_waddr;
  logic [VALUE_W-1:0]       pred_wdata;
  logic [VALUE_W-1:0]       pred_rdata;
  logic [VALUE_W-1:0]       predicted;

  assign clearing   = (state_r == ST_CLEAR);
  assign evaluating = (state_r == ST_EVAL);
  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;

  // control state: clear sweep, idle, evaluate
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CLR_BITS'(1);
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      p2_vld_r    <= evaluating;
      out_valid_r <= p2_vld_r;
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      pc_r  <= in_load_pc;
      val_r <= in_actual_value;
    end
  end

  // history RAM: read on request, write back while evaluating, swept to zero while clearing
  assign hist_we    = clearing || evaluating;
  assign hist_waddr = clearing ? clr_cnt_r[HIST_IDX_BITS-1:0] : pc_r[HIST_IDX_BITS-1:0];
  assign hist_wdata = clearing ? '0 : new_entry;

  clvp_ram #(
    .WIDTH     (ENT_W),
    .ADDR_BITS (HIST_IDX_BITS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (in_load_pc[HIST_IDX_BITS-1:0]),
    .rdata (hist_rdata)
  );

  // tag check, hashes and ring update
  clvp_ctx #(
    .HIST_IDX_BITS (HIST_IDX_BITS),
    .CTX_DEPTH     (CTX_DEPTH)
  ) u_ctx (
    .entry     (hist_rdata),
    .tag       (pc_r[PC_W-1:HIST_IDX_BITS]),
    .new_id    (value_id(val_r)),
    .ctx       (ctx),
    .new_entry (new_entry)
  );

  // second stage holding for the prediction table access
  always_ff @(posedge clk) begin
    if (evaluating) begin
      p2_hit_r  <= ctx.hit;
      p2_hash_r <= ctx.new_hash;
      p2_val_r  <= val_r;
    end
  end

  // prediction RAM: read at old context while evaluating, train at new context in the cycle after; swept while clearing
  assign pred_we    = clearing || p2_vld_r;
  assign pred_waddr = clearing ? clr_cnt_r[PRED_IDX_BITS-1:0] : PRED_IDX_BITS'(p2_hash_r);
  assign pred_wdata = clearing ? '0 : p2_val_r;

  clvp_ram #(
    .WIDTH     (VALUE_W),
    .ADDR_BITS (PRED_IDX_BITS)
  ) u_pred_ram (
    .clk   (clk),
    .we    (pred_we),
    .waddr (pred_waddr),
    .wdata (pred_wdata),
    .raddr (PRED_IDX_BITS'(ctx.old_hash)),
    .rdata (pred_rdata)
  );

  // result register
  assign predicted = p2_hit_r ? pred_rdata : '0;

  always_ff @(posedge clk) begin
    if (p2_vld_r) begin
      out_pred_r    <= predicted;
      out_correct_r <= (predicted == p2_val_r);
      out_hit_r     <= p2_hit_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_predicted_value    = out_pred_r;
  assign out_prediction_correct = out_correct_r;
  assign out_history_hit        = out_hit_r;

endmodule
